// File: sv/afc_pkg.sv
// ---------------------------------------------------------------------------
// afc_pkg
// Shared constants, CRC-8 helper and check-result type for the angle
// frame check.
// ---------------------------------------------------------------------------
package afc_pkg;

    localparam logic [7:0]  CRC_POLY   = 8'h1D;
    localparam logic [7:0]  CRC_INIT   = 8'hFF;
    localparam int unsigned STATUS_BIT = 12;
    localparam logic [15:0] CMD_RESET  = 16'h8021;

    // One byte through the CRC-8 shift register, MSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC state after the two command bytes of the reset command
    localparam logic [7:0] CMD_SEED_RESET =
        crc_byte(crc_byte(CRC_INIT, CMD_RESET[15:8]), CMD_RESET[7:0]);

    typedef struct packed {
        logic crc_match;
        logic status_set;
        logic ok;
    } t_chk;

endpackage

// File: sv/afc_cmd_seed.sv
// ---------------------------------------------------------------------------
// afc_cmd_seed
// Command register. Stores the CRC state after the command's high and low
// bytes, so the item path only runs the two angle bytes.
// ---------------------------------------------------------------------------
module afc_cmd_seed (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output logic [7:0] o_seed
);

    logic [7:0] r_seed;
    logic [7:0] n_seed;

    always_comb begin
        n_seed = afc_pkg::crc_byte(afc_pkg::crc_byte(afc_pkg::CRC_INIT,
                                                     i_cfg_wr_data[15:8]),
                                   i_cfg_wr_data[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= afc_pkg::CMD_SEED_RESET;
        end else if (i_cfg_wr_en) begin
            r_seed <= n_seed;
        end
    end

    assign o_seed = r_seed;

endmodule

// File: sv/afc_check.sv
// ---------------------------------------------------------------------------
// afc_check
// Finishes the CRC over the angle bytes, inverts it and compares it with
// the safety word; also reads the status flag.
// ---------------------------------------------------------------------------
module afc_check (
    input  logic [7:0]    i_seed,
    input  logic [15:0]   i_angle_word,
    input  logic [15:0]   i_safety_word,
    output afc_pkg::t_chk o_chk
);

    logic [7:0] crc;

    always_comb begin
        crc = ~afc_pkg::crc_byte(afc_pkg::crc_byte(i_seed, i_angle_word[15:8]),
                                 i_angle_word[7:0]);
        o_chk.crc_match  = (crc == i_safety_word[7:0]);
        o_chk.status_set = i_safety_word[afc_pkg::STATUS_BIT];
        o_chk.ok         = o_chk.crc_match && o_chk.status_set;
    end

endmodule

// File: sv/encoder_angle_frame_check.sv
// An accepted item waits in the input register, then moves on to the result register.
// Throughput: one item per cycle while i_out_stall is low; input register feeds the CRC check and
// the result register, each stage moves whenever the one after it frees.
// Reset (synchronous, active low): both stages empty, last good angle 0,
// command register back to the CRC seed of command 0x8021.
// ---------------------------------------------------------------------------
// encoder_angle_frame_check
// Angle-sensor reply check: CRC-8 over command and angle bytes plus the
// status flag; accepted angles are shifted left one and held.
// ---------------------------------------------------------------------------
module encoder_angle_frame_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_angle_word,
    input  logic [15:0]        i_safety_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_held_angle,
    output logic               o_accepted,
    output logic               o_crc_match,
    output logic               o_status_set
);

    logic [7:0]    seed;
    afc_pkg::t_chk chk;

    logic          r_in_valid;
    logic [15:0]   r_angle;
    logic [15:0]   r_safety;

    logic          r_out_valid;
    logic [15:0]   r_held;
    logic          r_accepted;
    logic          r_crc_match;
    logic          r_status_set;

    logic [15:0]   r_last_good;
    logic [15:0]   n_last_good;

    logic          out_load;
    logic          in_load;

    afc_cmd_seed u_seed (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_seed        (seed)
    );

    afc_check u_check (
        .i_seed        (seed),
        .i_angle_word  (r_angle),
        .i_safety_word (r_safety),
        .o_chk         (chk)
    );

    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    always_comb begin
        n_last_good = r_last_good;
        if (chk.ok) begin
            n_last_good = {r_angle[14:0], 1'b0};  // drop the top bit
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_good <= '0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_last_good <= n_last_good;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_angle  <= i_angle_word;
            r_safety <= i_safety_word;
        end
        if (out_load && r_in_valid) begin
            r_held       <= n_last_good;
            r_accepted   <= chk.ok;
            r_crc_match  <= chk.crc_match;
            r_status_set <= chk.status_set;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_held_angle = $signed(r_held);
    assign o_accepted   = r_accepted;
    assign o_crc_match  = r_crc_match;
    assign o_status_set = r_status_set;

endmodule

// File: sv/afc_checker.sv
// ---------------------------------------------------------------------------
// afc_checker
// Port-level checks on the angle frame check, bound to the top level.
// ---------------------------------------------------------------------------
module afc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_held_angle,
    input logic               o_accepted,
    input logic               o_crc_match,
    input logic               o_status_set
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_held_angle)
            && $stable(o_accepted))
        else $error("stalled result changed");

    a_accept_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_crc_match && o_status_set)
        else $error("accepted without both checks passing");

    a_accept_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> !(o_crc_match && o_status_set))
        else $error("both checks passed but reply rejected");

    // Held angle always comes from a left shift
    a_even_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_held_angle[0])
        else $error("held angle has bit 0 set");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind encoder_angle_frame_check afc_checker u_afc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_held_angle (o_held_angle),
    .o_accepted   (o_accepted),
    .o_crc_match  (o_crc_match),
    .o_status_set (o_status_set)
);
